// ----- sv/keyword_binary_search_unit_assert.svh -----
// Assertion helpers shared by the keyword search unit.
// Every use samples on the rising edge of clk and is off while rst_n is low.
`ifndef KEYWORD_BINARY_SEARCH_UNIT_ASSERT_SVH
`define KEYWORD_BINARY_SEARCH_UNIT_ASSERT_SVH

`define KBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define KBS_ASSERT_NEVER(lbl, cond, msg) \
  `KBS_ASSERT(lbl, !(cond), msg)

`endif

// ----- sv/kbs_pkg.sv -----
package kbs_pkg;

  localparam int CHAR_W     = 8;
  localparam int SLOT_IN_W  = 8;
  localparam int POS_IN_W   = 5;
  localparam int ECNT_W     = 9;
  localparam int INDEX_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_BANK_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

  localparam int QUEUE_DEPTH = 4;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_LOAD     = 2'd0;
  localparam cmd_code_t CMD_SYM      = 2'd1;
  localparam cmd_code_t CMD_SYM_LAST = 2'd2;

  typedef struct packed {
    cmd_code_t             code;
    logic                  bank;
    logic [SLOT_IN_W-1:0]  slot;
    logic [POS_IN_W-1:0]   pos;
    logic [CHAR_W-1:0]     ch;
  } cmd_t;

  typedef struct packed {
    logic              bank_select;
    logic [ECNT_W-1:0] entry_count;
  } cfg_t;

endpackage

// ----- sv/kbs_ram.sv -----
module kbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/kbs_front.sv -----
module kbs_front #(
  parameter int KEYWORDS = 256,
  parameter int MAX_LEN  = 32
) (
  input  logic                          push,
  input  logic                          mode,
  input  logic                          table_bank,
  input  logic [kbs_pkg::SLOT_IN_W-1:0] entry_slot,
  input  logic [kbs_pkg::POS_IN_W-1:0]  char_position,
  input  logic [kbs_pkg::CHAR_W-1:0]    char_value,
  input  logic                          last_char,
  output logic                          cmd_valid,
  output kbs_pkg::cmd_t                 cmd
);
  import kbs_pkg::*;

  logic load_in_range;

  // A load outside the table is dropped here and never reaches the queue.
  assign load_in_range = (int'(entry_slot) < KEYWORDS) && (int'(char_position) < MAX_LEN);

  always_comb begin
    cmd.bank = table_bank;
    cmd.slot = entry_slot;
    cmd.pos  = char_position;
    cmd.ch   = char_value;
    if (!mode) begin
      cmd.code  = CMD_LOAD;
      cmd_valid = push && load_in_range;
    end else begin
      cmd.code  = last_char ? CMD_SYM_LAST : CMD_SYM;
      cmd_valid = push;
    end
  end

endmodule

// ----- sv/kbs_fifo.sv -----
module kbs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kbs_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output kbs_pkg::cmd_t head,
  output logic          empty
);
  import kbs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/kbs_back.sv -----
`include "keyword_binary_search_unit_assert.svh"

module kbs_back #(
  parameter int KEYWORDS = 256,
  parameter int MAX_LEN  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kbs_pkg::cfg_t               cfg,
  input  kbs_pkg::cmd_t               cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_pop,
  output logic                        out_found,
  output logic [kbs_pkg::INDEX_W-1:0] out_index
);
  import kbs_pkg::*;

  localparam int SLOT_W = $clog2(KEYWORDS);
  localparam int POS_W  = $clog2(MAX_LEN);
  localparam int BW     = SLOT_W + 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 2);
  localparam int KW_AW  = 1 + SLOT_W + POS_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [BW-1:0]      lo_r, lo_nxt;
  logic [BW-1:0]      hi_ex_r, hi_ex_nxt;
  logic [SLOT_W-1:0]  mid_r, mid_nxt;
  logic [POS_W-1:0]   i_r, i_nxt;
  logic               found_r, found_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;

  logic               kw_we, kw_re;
  logic [KW_AW-1:0]   kw_waddr, kw_raddr;
  logic [CHAR_W-1:0]  kw_rdata;
  logic               sym_we, sym_re;
  logic [POS_W-1:0]   sym_raddr;
  logic [CHAR_W-1:0]  sym_rdata;

  logic               is_sym;
  logic [CNT_W-1:0]   cnt_inc;
  logic               overlong;
  logic [BW-1:0]      srch_cnt;
  logic [BW:0]        mid_sum;
  logic [BW-1:0]      mid_w;
  logic [CHAR_W-1:0]  sym_byte;
  logic               out_load;

  kbs_ram #(.WIDTH(CHAR_W), .DEPTH(2 ** KW_AW)) u_kw_ram (
    .clk   (clk),
    .we    (kw_we),
    .waddr (kw_waddr),
    .wdata (cmd.ch),
    .re    (kw_re),
    .raddr (kw_raddr),
    .rdata (kw_rdata)
  );

  kbs_ram #(.WIDTH(CHAR_W), .DEPTH(2 ** POS_W)) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (cnt_r[POS_W-1:0]),
    .wdata (cmd.ch),
    .re    (sym_re),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
  assign is_sym   = (cmd.code == CMD_SYM) || (cmd.code == CMD_SYM_LAST);
  assign kw_we    = cmd_pop && (cmd.code == CMD_LOAD);
  assign kw_waddr = {cmd.bank, SLOT_W'(cmd.slot), POS_W'(cmd.pos)};
  assign sym_we   = cmd_pop && is_sym && (int'(cnt_r) < MAX_LEN);

  assign cnt_inc  = (int'(cnt_r) <= MAX_LEN) ? cnt_r + CNT_W'(1) : cnt_r;
  assign overlong = int'(cnt_inc) > MAX_LEN;
  assign srch_cnt = (int'(cfg.entry_count) > KEYWORDS) ? BW'(KEYWORDS) : BW'(cfg.entry_count);

  // Bounds run as [lo, hi_ex); the midpoint is the floor of (lo + hi_ex - 1) / 2.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_ex_r} - (BW + 1)'(1);
  assign mid_w    = mid_sum[BW:1];

  // Symbol positions past its length read as zero, so the buffer needs no clearing.
  assign sym_byte = (CNT_W'(i_r) < len_r) ? sym_rdata : '0;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_pop);

  always_comb begin
    kw_re     = 1'b0;
    sym_re    = 1'b0;
    kw_raddr  = {cfg.bank_select, mid_r, i_r + POS_W'(1)};
    sym_raddr = i_r + POS_W'(1);
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    lo_nxt    = lo_r;
    hi_ex_nxt = hi_ex_r;
    mid_nxt   = mid_r;
    i_nxt     = i_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop && is_sym) begin
          cnt_nxt = cnt_inc;
          if (cmd.code == CMD_SYM_LAST) begin
            cnt_nxt   = '0;
            len_nxt   = overlong ? CNT_W'(MAX_LEN) : cnt_inc;
            lo_nxt    = '0;
            hi_ex_nxt = srch_cnt;
            found_nxt = 1'b0;
            idx_nxt   = '0;
            state_nxt = overlong ? ST_DONE : ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (lo_r < hi_ex_r) begin
          kw_re     = 1'b1;
          sym_re    = 1'b1;
          kw_raddr  = {cfg.bank_select, mid_w[SLOT_W-1:0], {POS_W{1'b0}}};
          sym_raddr = '0;
          mid_nxt   = mid_w[SLOT_W-1:0];
          i_nxt     = '0;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        if (sym_byte != kw_rdata) begin
          if (sym_byte < kw_rdata) begin
            hi_ex_nxt = {1'b0, mid_r};
          end else begin
            lo_nxt = {1'b0, mid_r} + BW'(1);
          end
          state_nxt = ST_PROBE;
        end else if ((sym_byte == '0) || (int'(i_r) == MAX_LEN - 1)) begin
          found_nxt = 1'b1;
          idx_nxt   = INDEX_W'(mid_r);
          state_nxt = ST_DONE;
        end else begin
          kw_re  = 1'b1;
          sym_re = 1'b1;
          i_nxt  = i_r + POS_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_r;
      out_idx_nxt   = idx_r;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      lo_r        <= '0;
      hi_ex_r     <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      lo_r        <= lo_nxt;
      hi_ex_r     <= hi_ex_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r       <= mid_nxt;
    found_r     <= found_nxt;
    idx_r       <= idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_index = out_idx_r;

  `KBS_ASSERT(a_probe_range, (state_r == ST_CMP) |-> (lo_r < hi_ex_r), "probe on empty range")
  `KBS_ASSERT(a_bound_cap, hi_ex_r <= BW'(KEYWORDS), "upper bound past table size")
  `KBS_ASSERT(a_result_hold, (out_valid_r && !out_pop) |=> (out_valid_r && $stable(out_idx_r) && $stable(out_found_r)), "waiting result changed")
  `KBS_ASSERT(a_result_src, $rose(out_valid_r) |-> ($past(state_r) == ST_DONE), "result not from a finished search")
  `KBS_ASSERT(a_miss_index, (out_valid_r && !out_found_r) |-> (out_idx_r == '0), "miss with nonzero index")
  `KBS_ASSERT_NEVER(a_cnt_cap, int'(cnt_r) > MAX_LEN + 1, "symbol count overran")

endmodule

// ----- sv/keyword_binary_search_unit.sv -----
// Keyword lookup by binary search over a sorted table of KEYWORDS entries per bank, each up to
// MAX_LEN bytes, compared as unsigned byte strings. Items pass through a four-entry command queue
// (full rises when it holds four) to a back end that takes one load or symbol character per cycle
// while it is idle. A final symbol character starts a search of at most ceil(log2(N+1)) probes,
// N being the entry count capped at KEYWORDS; each probe compares one entry byte by byte (up to
// MAX_LEN), as the keyword memory yields one byte per cycle on its single read port, and the
// result passes through the done state into the output register. An overlong symbol skips the
// search and answers as a miss. Keyword memory holds no valid state and needs no clearing pass
// after reset; only entries that were loaded may be searched. A result waits on the output ports
// until popped while the queue keeps taking items.
module keyword_binary_search_unit #(
  parameter int KEYWORDS = 256,
  parameter int MAX_LEN  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_mode,
  input  logic                           in_table_bank,
  input  logic [kbs_pkg::SLOT_IN_W-1:0]  in_entry_slot,
  input  logic [kbs_pkg::POS_IN_W-1:0]   in_char_position,
  input  logic [kbs_pkg::CHAR_W-1:0]     in_char_value,
  input  logic                           in_last_char,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_found,
  output logic [kbs_pkg::INDEX_W-1:0]    out_match_index,
  input  logic                           cfg_we,
  input  logic [kbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kbs_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t front_cmd, head_cmd;
  logic front_valid, q_full, q_empty, q_pop, out_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_BANK_SELECT: cfg_nxt.bank_select = cfg_wdata[0];
        REG_ENTRY_COUNT: cfg_nxt.entry_count = cfg_wdata[ECNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bank_select <= 1'b1;
      cfg_r.entry_count <= ECNT_W'(256);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kbs_front #(.KEYWORDS(KEYWORDS), .MAX_LEN(MAX_LEN)) u_front (
    .push          (in_push && !q_full),
    .mode          (in_mode),
    .table_bank    (in_table_bank),
    .entry_slot    (in_entry_slot),
    .char_position (in_char_position),
    .char_value    (in_char_value),
    .last_char     (in_last_char),
    .cmd_valid     (front_valid),
    .cmd           (front_cmd)
  );

  kbs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head_cmd),
    .empty     (q_empty)
  );

  kbs_back #(.KEYWORDS(KEYWORDS), .MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (head_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .out_found (out_found),
    .out_index (out_match_index)
  );

  assign in_full   = q_full;
  assign out_empty = !out_valid;

endmodule

// ----- verif/keyword_binary_search_unit_test.sv -----
`timescale 1ns / 1ps

module keyword_binary_search_unit_test;
  import kbs_pkg::*;

  localparam int KEYWORDS      = 256;
  localparam int MAX_LEN       = 32;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 400;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SYMBOL = 1'b1;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KEY, ROW_CFG} row_kind_t;
  typedef enum logic [2:0] {
    SYM_HIT, SYM_TERMINATED, SYM_MISS, SYM_OVERLONG, SYM_NOISE
  } sym_variant_t;

  typedef struct packed {
    logic                 mode;
    logic                 bank;
    logic [SLOT_IN_W-1:0] slot;
    logic [POS_IN_W-1:0]  pos;
    logic [CHAR_W-1:0]    ch;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [INDEX_W-1:0] index;
  } lookup_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  mode;
    logic                  bank;
    logic [SLOT_IN_W-1:0]  slot;
    logic [POS_IN_W-1:0]   pos;
    logic [CHAR_W-1:0]     ch;
    logic [5:0]            reps;
    logic                  last;
    logic                  typed;
    logic                  exp_found;
    logic [INDEX_W-1:0]    exp_index;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_mode;
  logic                  in_table_bank;
  logic [SLOT_IN_W-1:0]  in_entry_slot;
  logic [POS_IN_W-1:0]   in_char_position;
  logic [CHAR_W-1:0]     in_char_value;
  logic                  in_last_char;
  logic                  out_empty;
  logic                  out_pop;
  logic                  out_found;
  logic [INDEX_W-1:0]    out_match_index;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Mirror of the block's state as seen through its ports.
  logic [CHAR_W-1:0]     kw_store [2][KEYWORDS][MAX_LEN];
  logic [CHAR_W-1:0]     sym_buf [MAX_LEN];
  int                    sym_count;
  logic                  cfg_bank_sel;
  logic [CFG_DATA_W-1:0] cfg_count;

  lookup_t               match_queue [$];
  lookup_t               head_match;
  logic [CHAR_W-1:0]     symbol_chars [$];
  plan_row_t             plan [$];
  in_item_t              row_item;
  int                    error_count = 0;
  int                    items_sent = 0;
  int                    tx_idle_pct = 10;
  int                    rx_idle_pct = 10;
  bit                    hold_request = 1'b0;
  int                    hold_left = 0;

  keyword_binary_search_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_table_bank    (in_table_bank),
    .in_entry_slot    (in_entry_slot),
    .in_char_position (in_char_position),
    .in_char_value    (in_char_value),
    .in_last_char     (in_last_char),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_found        (out_found),
    .out_match_index  (out_match_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int compare_key(logic bank, int slot);
    logic [CHAR_W-1:0] a;
    logic [CHAR_W-1:0] b;
    for (int i = 0; i < MAX_LEN; i++) begin
      a = sym_buf[i];
      b = kw_store[bank][slot][i];
      if (a != b) return (a < b) ? -1 : 1;
      if (a == 0) return 0;
    end
    return 0;
  endfunction

  // Applies one accepted item to the mirrored state and returns the lookup it completes.
  function automatic lookup_t apply_item(in_item_t it);
    lookup_t r;
    int      cnt;
    int      lo;
    int      hi;
    int      mid;
    int      c;
    bit      hit;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      kw_store[it.bank][it.slot][it.pos] = it.ch;
      return r;
    end
    if (sym_count < MAX_LEN) sym_buf[sym_count] = it.ch;
    if (sym_count <= MAX_LEN) sym_count++;
    if (!it.last) return r;
    r.valid = 1'b1;
    cnt = (cfg_count > KEYWORDS) ? KEYWORDS : int'(cfg_count);
    if (sym_count <= MAX_LEN && cnt > 0) begin
      lo = 0;
      hi = cnt - 1;
      hit = 1'b0;
      while (!hit && lo <= hi) begin
        mid = (lo + hi) / 2;
        c = compare_key(cfg_bank_sel, mid);
        if (c == 0) begin
          hit = 1'b1;
          r.found = 1'b1;
          r.index = mid[INDEX_W-1:0];
        end else if (c < 0) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    for (int i = 0; i < MAX_LEN; i++) sym_buf[i] = '0;
    sym_count = 0;
    return r;
  endfunction

  function automatic plan_row_t sym_row(logic [CHAR_W-1:0] ch, int reps, logic last,
                                        logic typed, logic f, logic [INDEX_W-1:0] idx);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mode = MODE_SYMBOL;
    r.ch = ch;
    r.reps = reps[5:0];
    r.last = last;
    r.typed = typed;
    r.exp_found = f;
    r.exp_index = idx;
    return r;
  endfunction

  function automatic plan_row_t load_row(logic bank, int slot, int pos, logic [CHAR_W-1:0] ch);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mode = MODE_LOAD;
    r.bank = bank;
    r.slot = slot[SLOT_IN_W-1:0];
    r.pos = pos[POS_IN_W-1:0];
    r.ch = ch;
    r.reps = 6'd1;
    return r;
  endfunction

  function automatic plan_row_t key_row(int slot);
    plan_row_t r;
    r = '0;
    r.kind = ROW_KEY;
    r.slot = slot[SLOT_IN_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val[CFG_DATA_W-1:0];
    return r;
  endfunction

  // Fields that a symbol item ignores still get random values.
  function automatic in_item_t symbol_item(logic [CHAR_W-1:0] ch, logic last);
    in_item_t it;
    it.mode = MODE_SYMBOL;
    it.bank = $urandom_range(1);
    it.slot = $urandom_range(255);
    it.pos = $urandom_range(31);
    it.ch = ch;
    it.last = last;
    return it;
  endfunction

  function automatic in_item_t load_item(logic bank, int slot, int pos, logic [CHAR_W-1:0] ch);
    in_item_t it;
    it.mode = MODE_LOAD;
    it.bank = bank;
    it.slot = slot[SLOT_IN_W-1:0];
    it.pos = pos[POS_IN_W-1:0];
    it.ch = ch;
    it.last = $urandom_range(1);
    return it;
  endfunction

  // Entry 0 is the empty string; entries 1 and 255 are one byte; entry 128 fills all positions.
  function automatic int entry_len(int slot);
    if (slot == 128) return MAX_LEN;
    if (slot <= 1 || slot == KEYWORDS - 1) return 1;
    return ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, MAX_LEN);
  endfunction

  function automatic int pick_slot();
    int eff;
    eff = (cfg_count > KEYWORDS) ? KEYWORDS : int'(cfg_count);
    if (eff == 0 || $urandom_range(9) == 0) return $urandom_range(0, KEYWORDS - 1);
    return $urandom_range(0, eff - 1);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_item(in_item_t it, logic typed, logic f, logic [INDEX_W-1:0] idx);
    lookup_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_mode <= it.mode;
    in_table_bank <= it.bank;
    in_entry_slot <= it.slot;
    in_char_position <= it.pos;
    in_char_value <= it.ch;
    in_last_char <= it.last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    r = apply_item(it);
    if (r.valid) begin
      if (typed) begin
        r.found = f;
        r.index = idx;
      end
      match_queue.push_back(r);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_symbol();
    int n;
    n = symbol_chars.size();
    for (int i = 0; i < n; i++) offer_item(symbol_item(symbol_chars[i], i == n - 1), 0, 0, '0);
    symbol_chars.delete();
  endtask

  // Entries are fully loaded with distinct leading bytes, so the table stays sorted.
  task automatic load_keyword(logic bank, int slot, int len);
    logic [CHAR_W-1:0] ch;
    for (int p = 0; p < MAX_LEN; p++) begin
      if (p == 0) ch = slot[CHAR_W-1:0];
      else if (p < len) ch = $urandom_range(1, 255);
      else ch = '0;
      offer_item(load_item(bank, slot, p, ch), 0, 0, '0);
    end
  endtask

  task automatic send_lookup(sym_variant_t v, int slot);
    int n;
    symbol_chars.delete();
    case (v)
      SYM_OVERLONG: begin
        n = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
        repeat (n) symbol_chars.push_back($urandom_range(1, 255));
      end
      SYM_NOISE: begin
        n = $urandom_range(1, 6);
        repeat (n) symbol_chars.push_back($urandom_range(0, 255));
      end
      default: begin
        for (int k = 0; k < MAX_LEN && kw_store[cfg_bank_sel][slot][k] != 0; k++)
          symbol_chars.push_back(kw_store[cfg_bank_sel][slot][k]);
        if (symbol_chars.size() == 0) symbol_chars.push_back(8'h00);
        if (v == SYM_TERMINATED) begin
          // A zero ends the symbol for comparison; whatever follows is junk.
          symbol_chars.push_back(8'h00);
          repeat ($urandom_range(0, 3)) symbol_chars.push_back($urandom_range(0, 255));
        end else if (v == SYM_MISS) begin
          case ($urandom_range(2))
            0: symbol_chars[$urandom_range(0, symbol_chars.size() - 1)] = $urandom_range(1, 255);
            1: symbol_chars.push_back($urandom_range(1, 255));
            default: begin
              if (symbol_chars.size() > 1) void'(symbol_chars.pop_back());
              else symbol_chars.push_back($urandom_range(1, 255));
            end
          endcase
        end
      end
    endcase
    send_symbol();
  endtask

  // Wait until every lookup has answered, then let any trailing work finish.
  task automatic settle();
    in_push <= 1'b0;
    while (match_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BANK_SELECT) cfg_bank_sel = val[0];
    else if (idx == REG_ENTRY_COUNT) cfg_count = val;
    @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 50) send_lookup(SYM_HIT, pick_slot());
      else if (pick < 60) send_lookup(SYM_TERMINATED, pick_slot());
      else if (pick < 75) send_lookup(SYM_MISS, pick_slot());
      else if (pick < 80) send_lookup(SYM_OVERLONG, 0);
      else if (pick < 85) send_lookup(SYM_NOISE, 0);
      else if (pick < 97)
        offer_item(load_item($urandom_range(1), $urandom_range(255), $urandom_range(31),
                             $urandom_range(255)), 0, 0, '0);
      else begin
        pick = $urandom_range(0, KEYWORDS - 1);
        load_keyword($urandom_range(1), pick, entry_len(pick));
      end
    end
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (match_queue.size() == 0) begin
        $error("result with no lookup pending: found %0d match_index %0d",
               out_found, out_match_index);
        error_count++;
      end else begin
        head_match = match_queue.pop_front();
        if (out_found !== head_match.found) begin
          $error("found: expected %0d, actual %0d", head_match.found, out_found);
          error_count++;
        end
        if (out_match_index !== head_match.index) begin
          $error("match_index: expected %0d, actual %0d", head_match.index, out_match_index);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_mode = MODE_LOAD;
    in_table_bank = 1'b0;
    in_entry_slot = '0;
    in_char_position = '0;
    in_char_value = '0;
    in_last_char = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BANK_SELECT;
    cfg_wdata = '0;
    cfg_bank_sel = 1'b1;
    cfg_count = 9'd256;
    sym_count = 0;
    for (int i = 0; i < MAX_LEN; i++) sym_buf[i] = '0;

    // Rows before the first register write run with the reset settings.
    plan.push_back(sym_row(8'h00, 1, 1, 1, 1, 8'd0));
    plan.push_back(sym_row(8'h01, 1, 1, 1, 1, 8'd1));
    plan.push_back(sym_row(8'hFF, 1, 1, 1, 1, 8'd255));
    plan.push_back(sym_row(8'h01, 1, 0, 0, 0, 8'd0));
    plan.push_back(sym_row(8'h00, 1, 0, 0, 0, 8'd0));
    plan.push_back(sym_row(8'h41, 1, 1, 1, 1, 8'd1));
    plan.push_back(sym_row(8'h41, MAX_LEN + 1, 1, 1, 0, 8'd0));
    plan.push_back(key_row(128));
    plan.push_back(key_row(77));
    plan.push_back(load_row(1'b1, 255, 31, 8'hFF));
    plan.push_back(load_row(1'b0, 0, 31, 8'h00));
    plan.push_back(cfg_row(REG_ENTRY_COUNT, 1));
    plan.push_back(sym_row(8'h00, 1, 1, 1, 1, 8'd0));
    plan.push_back(sym_row(8'h01, 1, 1, 1, 0, 8'd0));
    plan.push_back(cfg_row(REG_ENTRY_COUNT, 0));
    plan.push_back(sym_row(8'h00, 1, 1, 1, 0, 8'd0));
    plan.push_back(cfg_row(REG_ENTRY_COUNT, 511));
    plan.push_back(sym_row(8'hFF, 1, 1, 1, 1, 8'd255));
    plan.push_back(cfg_row(REG_BANK_SELECT, 0));
    plan.push_back(cfg_row(REG_ENTRY_COUNT, 256));
    plan.push_back(sym_row(8'hFF, 1, 1, 1, 1, 8'd255));
    plan.push_back(key_row(200));
    plan.push_back(sym_row(8'h80, MAX_LEN, 1, 0, 0, 8'd0));
    plan.push_back(cfg_row(REG_BANK_SELECT, 1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int b = 0; b < 2; b++)
      for (int s = 0; s < KEYWORDS; s++) load_keyword(b[0], s, entry_len(s));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[i].reg_idx, plan[i].reg_val);
        end
        ROW_KEY: send_lookup(SYM_HIT, plan[i].slot);
        default: begin
          for (int r = 0; r < plan[i].reps; r++) begin
            row_item.mode = plan[i].mode;
            row_item.bank = plan[i].bank;
            row_item.slot = plan[i].slot;
            row_item.pos = plan[i].pos;
            row_item.ch = plan[i].ch;
            row_item.last = plan[i].last && (r == plan[i].reps - 1);
            offer_item(row_item, plan[i].typed, plan[i].exp_found, plan[i].exp_index);
          end
        end
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_reg(REG_BANK_SELECT, ph[0] ? 1'b0 : 1'b1);
      case (ph)
        0: write_reg(REG_ENTRY_COUNT, 9'd256);
        2: write_reg(REG_ENTRY_COUNT, $urandom_range(3, 255));
        3: write_reg(REG_ENTRY_COUNT, 9'd2);
        4: write_reg(REG_ENTRY_COUNT, 9'd255);
        5: write_reg(REG_ENTRY_COUNT, $urandom_range(1, 256));
        6: write_reg(REG_ENTRY_COUNT, 9'd300);
        default: write_reg(REG_ENTRY_COUNT, 9'd256);
      endcase
      tx_idle_pct = (ph == 4) ? 0 : 10;
      rx_idle_pct = (ph == 4) ? 0 : 10;
      if (ph == 2) begin
        // The receiver stalls while lookups keep coming, so the input side backs up.
        hold_request = 1'b1;
        repeat (10) send_lookup(SYM_HIT, pick_slot());
      end
      random_phase(28);
      if (ph == 7) settle();
      random_phase(28);
    end

    settle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
